// ===== design/psu_pkg.sv =====
// ---------------------------------------------------------------------------
// psu_pkg
// shared types, constants and the paeth predictor for the png scanline
// unfilter unit
// ---------------------------------------------------------------------------
package psu_pkg;

  localparam int MAX_WIDTH_DEF = 4096;
  localparam int WIDTH_W       = 13;
  localparam int HEIGHT_W      = 16;
  localparam int CHANS_W       = 3;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 16;
  localparam int QUEUE_DEPTH   = 4;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNELS     = 2'd2;

  localparam logic [CHANS_W-1:0] CHANS_RGB  = 3'd3;
  localparam logic [CHANS_W-1:0] CHANS_RGBA = 3'd4;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4
  } filt_t;

  typedef enum logic [1:0] {
    OP_FILTER  = 2'd0,
    OP_CHANNEL = 2'd1,
    OP_ERROR   = 2'd2
  } op_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_of_image;
  } psu_in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       row_done;
    logic       image_done;
    logic       bad_filter;
  } psu_out_t;

  // one classified request travelling from front to back
  typedef struct packed {
    op_t        op;
    filt_t      filt;
    logic [7:0] data_byte;
    logic [1:0] chan;
    logic       first_row;
    logic       last_chan;
    logic       row_end;
    logic       img_end;
    logic       rgb;
  } psu_item_t;

  localparam int ITEM_W = $bits(psu_item_t);

  function automatic logic [7:0] paeth_pred(input logic [7:0] a, input logic [7:0] b,
                                            input logic [7:0] c);
    logic signed [9:0] pa;
    logic signed [9:0] pb;
    logic signed [9:0] pc;
    pa = $signed({2'b00, b}) - $signed({2'b00, c});
    pb = $signed({2'b00, a}) - $signed({2'b00, c});
    pc = $signed({2'b00, a}) + $signed({2'b00, b}) - $signed({1'b0, c, 1'b0});
    if (pa < 0) pa = -pa;
    if (pb < 0) pb = -pb;
    if (pc < 0) pc = -pc;
    if (pa <= pb && pa <= pc) return a;
    else if (pb <= pc)        return b;
    else                      return c;
  endfunction

endpackage

// ===== design/psu_front.sv =====
// ---------------------------------------------------------------------------
// psu_front
// takes stream bytes, holds the configuration, tracks row and pixel
// position and classifies each byte into a request for the back end
// ---------------------------------------------------------------------------
module psu_front #(
  parameter int MAX_WIDTH = psu_pkg::MAX_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  psu_pkg::psu_in_t                  in_data,
  input  logic                              cfg_we,
  input  logic [psu_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [psu_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output logic                              q_push,
  output psu_pkg::psu_item_t                q_item,
  output logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0] q_col,
  input  logic                              q_full
);
  import psu_pkg::*;

  localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CMP_W = ((COL_W + 1) > WIDTH_W) ? (COL_W + 1) : WIDTH_W;

  logic [WIDTH_W-1:0]  width_r;
  logic [HEIGHT_W-1:0] height_r;
  logic [CHANS_W-1:0]  chans_r;

  logic                awaiting_r, awaiting_nxt;
  logic                first_row_r, first_row_nxt;
  logic                sticky_r, sticky_nxt;
  filt_t               filt_r, filt_nxt;
  logic [COL_W-1:0]    col_r, col_nxt;
  logic [1:0]          ch_r, ch_nxt;
  logic [HEIGHT_W-1:0] row_r, row_nxt;

  logic                in_fire;
  logic                cur_awaiting, cur_first_row, cur_sticky;
  filt_t               cur_filt;
  logic [COL_W-1:0]    cur_col;
  logic [1:0]          cur_ch;
  logic [HEIGHT_W-1:0] cur_row;
  logic                rgb;
  logic                last_chan;
  logic [CMP_W-1:0]    w_ext, w_eff, col_ext;
  logic [HEIGHT_W-1:0] h_m1;
  logic                row_end, img_end;
  logic                bad_byte;

  assign in_stall = q_full;
  assign in_fire  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_W'(1);
      height_r <= HEIGHT_W'(1);
      chans_r  <= CHANS_RGBA;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  width_r  <= cfg_wdata[WIDTH_W-1:0];
        REG_IMAGE_HEIGHT: height_r <= cfg_wdata[HEIGHT_W-1:0];
        REG_CHANNELS:     chans_r  <= cfg_wdata[CHANS_W-1:0];
        default: ;
      endcase
    end
  end

  // effective geometry: width 0 acts as 1 and is clamped to the line store
  always_comb begin
    w_ext = (width_r == '0) ? CMP_W'(1) : CMP_W'(width_r);
    w_eff = (w_ext > CMP_W'(MAX_WIDTH)) ? CMP_W'(MAX_WIDTH) : w_ext;
    h_m1  = (height_r == '0) ? '0 : height_r - HEIGHT_W'(1);
  end

  assign rgb = (chans_r == CHANS_RGB);

  always_comb begin
    // a new image mark restarts everything before the byte is looked at
    if (in_data.first_of_image) begin
      cur_awaiting  = 1'b1;
      cur_first_row = 1'b1;
      cur_sticky    = 1'b0;
      cur_filt      = FILT_NONE;
      cur_col       = '0;
      cur_ch        = '0;
      cur_row       = '0;
    end else begin
      cur_awaiting  = awaiting_r;
      cur_first_row = first_row_r;
      cur_sticky    = sticky_r;
      cur_filt      = filt_r;
      cur_col       = col_r;
      cur_ch        = ch_r;
      cur_row       = row_r;
    end
    col_ext   = CMP_W'(cur_col);
    row_end   = (col_ext + CMP_W'(1)) >= w_eff;
    img_end   = row_end && (cur_row >= h_m1);
    // a pixel left on its fourth channel after a switch to rgb also closes
    last_chan = rgb ? (cur_ch >= 2'd2) : (cur_ch == 2'd3);
    bad_byte  = in_data.data_byte > {5'd0, FILT_PAETH};
  end

  always_comb begin
    awaiting_nxt  = awaiting_r;
    first_row_nxt = first_row_r;
    sticky_nxt    = sticky_r;
    filt_nxt      = filt_r;
    col_nxt       = col_r;
    ch_nxt        = ch_r;
    row_nxt       = row_r;
    q_push        = 1'b0;
    q_item        = '0;
    q_col         = cur_col;
    q_item.filt      = cur_filt;
    q_item.data_byte = in_data.data_byte;
    q_item.chan      = cur_ch;
    q_item.first_row = cur_first_row;
    q_item.last_chan = last_chan;
    q_item.row_end   = row_end;
    q_item.img_end   = img_end;
    q_item.rgb       = rgb;
    if (in_fire) begin
      awaiting_nxt  = cur_awaiting;
      first_row_nxt = cur_first_row;
      sticky_nxt    = cur_sticky;
      filt_nxt      = cur_filt;
      col_nxt       = cur_col;
      ch_nxt        = cur_ch;
      row_nxt       = cur_row;
      priority if (cur_sticky) begin
        // dropped until the next image mark
      end else if (cur_awaiting && bad_byte) begin
        q_push     = 1'b1;
        q_item.op  = OP_ERROR;
        sticky_nxt = 1'b1;
      end else if (cur_awaiting) begin
        q_push       = 1'b1;
        q_item.op    = OP_FILTER;
        filt_nxt     = filt_t'(in_data.data_byte[2:0]);
        awaiting_nxt = 1'b0;
        col_nxt      = '0;
        ch_nxt       = '0;
      end else begin
        q_push    = 1'b1;
        q_item.op = OP_CHANNEL;
        if (!last_chan) begin
          ch_nxt = cur_ch + 2'd1;
        end else begin
          ch_nxt = '0;
          if (img_end) begin
            awaiting_nxt  = 1'b1;
            first_row_nxt = 1'b1;
            sticky_nxt    = 1'b0;
            filt_nxt      = FILT_NONE;
            col_nxt       = '0;
            row_nxt       = '0;
          end else if (row_end) begin
            row_nxt       = cur_row + HEIGHT_W'(1);
            first_row_nxt = 1'b0;
            awaiting_nxt  = 1'b1;
            col_nxt       = '0;
          end else begin
            col_nxt = cur_col + COL_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      awaiting_r  <= 1'b1;
      first_row_r <= 1'b1;
      sticky_r    <= 1'b0;
      filt_r      <= FILT_NONE;
      col_r       <= '0;
      ch_r        <= '0;
      row_r       <= '0;
    end else begin
      awaiting_r  <= awaiting_nxt;
      first_row_r <= first_row_nxt;
      sticky_r    <= sticky_nxt;
      filt_r      <= filt_nxt;
      col_r       <= col_nxt;
      ch_r        <= ch_nxt;
      row_r       <= row_nxt;
    end
  end

endmodule

// ===== design/psu_queue.sv =====
// ---------------------------------------------------------------------------
// psu_queue
// short first-in first-out queue of requests between front and back
// ---------------------------------------------------------------------------
module psu_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  input  logic         pop,
  output logic [W-1:0] head_data,
  output logic         empty,
  output logic         full
);
  import psu_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [W-1:0]     slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign empty     = (count_r == '0);
  assign full      = (count_r == CNT_W'(QUEUE_DEPTH));
  assign head_data = slot_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) count_nxt = count_r + CNT_W'(1);
    else if (!do_push && do_pop) count_nxt = count_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== design/psu_back.sv =====
// ---------------------------------------------------------------------------
// psu_back
// reads the line store, reconstructs channel bytes and drives the result
// register
// ---------------------------------------------------------------------------
module psu_back #(
  parameter int MAX_WIDTH = psu_pkg::MAX_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  psu_pkg::psu_item_t                q_item,
  input  logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0] q_col,
  input  logic                              q_empty,
  output logic                              q_pop,
  output logic                              out_valid,
  input  logic                              out_stall,
  output psu_pkg::psu_out_t                 out_data
);
  import psu_pkg::*;

  localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int ADDR_W = COL_W + 2;
  localparam int DEPTH  = MAX_WIDTH * 4;

  logic [7:0]        line_mem [DEPTH];
  logic [7:0]        rd_data_r;

  logic              s1_valid_r, s1_valid_nxt;
  psu_item_t         s1_item_r;
  logic [COL_W-1:0]  s1_col_r;

  logic [31:0]       left_r, upper_r;
  logic              out_valid_r;
  psu_out_t          out_data_r;

  logic              out_free, s1_fire, has_result;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic [7:0]        a_byte, b_byte, c_byte, pred, val;
  logic [8:0]        sum_ab;
  logic [31:0]       left_upd, upper_upd;
  psu_out_t          res;

  assign out_free = !out_valid_r || !out_stall;
  assign s1_fire  = s1_valid_r && out_free;
  assign q_pop    = !q_empty && (!s1_valid_r || out_free);
  assign rd_addr  = {q_col, q_item.chan};
  assign wr_addr  = {s1_col_r, s1_item_r.chan};

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (q_pop)        s1_valid_nxt = 1'b1;
    else if (s1_fire) s1_valid_nxt = 1'b0;
  end

  // reconstruction of one channel byte
  always_comb begin
    a_byte = left_r[{s1_item_r.chan, 3'b000} +: 8];
    b_byte = s1_item_r.first_row ? 8'd0 : rd_data_r;
    c_byte = s1_item_r.first_row ? 8'd0 : upper_r[{s1_item_r.chan, 3'b000} +: 8];
    sum_ab = {1'b0, a_byte} + {1'b0, b_byte};
    unique case (s1_item_r.filt)
      FILT_SUB:   pred = a_byte;
      FILT_UP:    pred = b_byte;
      FILT_AVG:   pred = sum_ab[8:1];
      FILT_PAETH: pred = paeth_pred(a_byte, b_byte, c_byte);
      default:    pred = 8'd0;
    endcase
    val = s1_item_r.data_byte + pred;
    for (int k = 0; k < 4; k++) begin
      left_upd[k*8 +: 8]  = (s1_item_r.chan == 2'(k)) ? val : left_r[k*8 +: 8];
      upper_upd[k*8 +: 8] = (s1_item_r.chan == 2'(k)) ? b_byte : upper_r[k*8 +: 8];
    end
  end

  always_comb begin
    res        = '0;
    has_result = 1'b0;
    unique case (s1_item_r.op)
      OP_CHANNEL: begin
        has_result     = s1_item_r.last_chan;
        res.red        = left_upd[7:0];
        res.green      = left_upd[15:8];
        res.blue       = left_upd[23:16];
        res.alpha      = s1_item_r.rgb ? ALPHA_OPAQUE : left_upd[31:24];
        res.row_done   = s1_item_r.row_end;
        res.image_done = s1_item_r.img_end;
      end
      OP_ERROR: begin
        has_result     = 1'b1;
        res.bad_filter = 1'b1;
      end
      default: ;
    endcase
  end

  // line store: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (s1_fire && s1_item_r.op == OP_CHANNEL) line_mem[wr_addr] <= val;
    if (q_pop) rd_data_r <= line_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_item_r <= q_item;
      s1_col_r  <= q_col;
    end
    if (s1_fire && has_result) out_data_r <= res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      left_r      <= '0;
      upper_r     <= '0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (s1_fire && has_result) out_valid_r <= 1'b1;
      else if (!out_stall)       out_valid_r <= 1'b0;
      if (s1_fire) begin
        unique case (s1_item_r.op)
          OP_FILTER: begin
            left_r  <= '0;
            upper_r <= '0;
          end
          OP_CHANNEL: begin
            left_r  <= left_upd;
            upper_r <= upper_upd;
          end
          default: ;
        endcase
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== design/png_scanline_unfilter_unit.sv =====
// ---------------------------------------------------------------------------
// png_scanline_unfilter_unit
// png row filter reconstruction (none, sub, up, average, paeth) on an
// inflated byte stream, one rgba result per completed pixel
// ---------------------------------------------------------------------------
// throughput: one stream byte per clock unless the queue is full, limited
//   by the single line store port pair (one read at queue pop, one write
//   at reconstruction); path: queue slot, s1 register, result register
// reset: synchronous, active low; counters, queue and result valid flag clear,
//   the line store is not cleared and the first row of an image reads as zero
// ---------------------------------------------------------------------------
module png_scanline_unfilter_unit #(
  parameter int MAX_WIDTH = psu_pkg::MAX_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  psu_pkg::psu_in_t               in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output psu_pkg::psu_out_t              out_data,
  input  logic                           cfg_we,
  input  logic [psu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [psu_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import psu_pkg::*;

  // column index into the line store
  localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int Q_W   = ITEM_W + COL_W;

  // front to queue
  logic             push;
  psu_item_t        push_item;
  logic [COL_W-1:0] push_col;
  logic             q_full;

  // queue to back
  logic             q_empty;
  logic             q_pop;
  logic [Q_W-1:0]   head_bits;
  psu_item_t        head_item;
  logic [COL_W-1:0] head_col;

  // front: configuration, position tracking and byte classification
  psu_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_push    (push),
    .q_item    (push_item),
    .q_col     (push_col),
    .q_full    (q_full)
  );

  // decoupling queue; the front stalls only when it is full
  psu_queue #(
    .W (Q_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({push_item, push_col}),
    .pop       (q_pop),
    .head_data (head_bits),
    .empty     (q_empty),
    .full      (q_full)
  );

  assign head_item = psu_item_t'(head_bits[Q_W-1:COL_W]);
  assign head_col  = head_bits[COL_W-1:0];

  // back: line store, predictor and result register
  psu_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_item    (head_item),
    .q_col     (head_col),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
